@@ sv/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 32;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [23:0] MIN_INTERVAL = 24'd1;

    typedef enum logic [1:0] {
        FN_REGISTER   = 2'd0,
        FN_UNREGISTER = 2'd1,
        FN_ADVANCE    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  timer_index;
        logic [23:0] interval;
        logic [31:0] context_req;
        logic [1:0]  tick_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  fired_index;
        logic [31:0] fired_context;
        logic [31:0] fire_time;
        logic        last;
    } t_out_item;

    // one table entry as held in the timer memory
    typedef struct packed {
        logic [23:0]          period;
        logic [TIME_BITS-1:0] due;
        logic [31:0]          user_word;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ sv/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// ptt_ram
// Simple dual-port RAM, one write and one registered read per cycle, with
// write-to-read bypass when both ports address the same entry.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/periodic_timer_table.sv @@
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers advanced by a wrapping tick time.
// ----------------------------------------------------------------------------
// Register and unregister transfers leave the block idle and ready. An advance
// transfer scans the timer memory once per tick, one entry per cycle through its
// single read port while the result side does not hold off the scan, and
// occupies the block until the scan and the flush of its held expiry are done.
// Expiries leave in tick order and, within a tick, in ascending index order;
// the final expiry of an advance carries last. A new input transfer is taken
// once the previous advance has handed over all its results to the output
// register.
module periodic_timer_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptt_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ptt_pkg::t_out_item o_out_data
);
    import ptt_pkg::*;

    t_state               r_state, n_state;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [TIME_BITS-1:0] r_time;
    logic [1:0]           r_ticks_left;
    logic [IDX_W-1:0]     r_rd_idx;

    logic                 r_chk_valid;
    logic [IDX_W-1:0]     r_chk_idx;
    logic [TIME_BITS-1:0] r_chk_time;

    logic                 r_pend_valid;
    t_out_item            r_pend;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 in_acc;
    logic                 idx_ok;
    logic [23:0]          per_fix;
    t_entry               chk_entry;
    t_entry               reg_entry;
    t_entry               upd_entry;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 hit;
    logic                 out_free;
    logic                 stall;
    logic                 issue;
    logic                 last_idx;
    logic                 reg_we;
    logic                 flush_push;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    t_out_item            hit_item;
    t_out_item            pend_out;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_ok     = (int'(i_in_data.timer_index) < NUM_TIMERS);
    assign per_fix    = (i_in_data.interval == '0) ? MIN_INTERVAL : i_in_data.interval;

    assign reg_entry.period    = per_fix;
    assign reg_entry.due       = r_time + TIME_BITS'(per_fix);
    assign reg_entry.user_word = i_in_data.context_req;

    assign chk_entry = t_entry'(ram_rdata);
    assign hit       = r_chk_valid && r_armed[r_chk_idx] && (chk_entry.due == r_chk_time);
    assign out_free  = !r_out_valid || i_out_ready;
    // a second expiry needs the held one moved on first
    assign stall     = hit && r_pend_valid && !out_free;
    assign issue     = (r_state == ST_SCAN) && (r_ticks_left != '0) && !stall;
    assign last_idx  = (r_rd_idx == IDX_W'(NUM_TIMERS - 1));

    assign upd_entry.period    = chk_entry.period;
    assign upd_entry.due       = r_chk_time + TIME_BITS'(chk_entry.period);
    assign upd_entry.user_word = chk_entry.user_word;

    assign hit_item.fired_index   = 4'(r_chk_idx);
    assign hit_item.fired_context = chk_entry.user_word;
    assign hit_item.fire_time     = 32'(r_chk_time);
    assign hit_item.last          = 1'b0;

    assign reg_we = in_acc && (i_in_data.func == FN_REGISTER) && idx_ok;

    always_comb begin
        if (reg_we) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(i_in_data.timer_index);
            ram_wdata = reg_entry;
        end else begin
            ram_we    = hit && !stall;
            ram_waddr = r_chk_idx;
            ram_wdata = upd_entry;
        end
    end

    ptt_ram #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign flush_push = (r_state == ST_FLUSH) && r_pend_valid && out_free;

    // held expiry, marked last only when the scan is over
    always_comb begin
        pend_out      = r_pend;
        pend_out.last = flush_push;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.func == FN_ADVANCE)
                        && (i_in_data.tick_count != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((r_ticks_left == '0) && !r_chk_valid) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= '0;
            r_time       <= '0;
            r_ticks_left <= '0;
            r_rd_idx     <= '0;
            r_chk_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc && idx_ok) begin
                if (i_in_data.func == FN_REGISTER) begin
                    r_armed[IDX_W'(i_in_data.timer_index)] <= 1'b1;
                end else if (i_in_data.func == FN_UNREGISTER) begin
                    r_armed[IDX_W'(i_in_data.timer_index)] <= 1'b0;
                end
            end

            if (in_acc && (i_in_data.func == FN_ADVANCE)) begin
                r_ticks_left <= i_in_data.tick_count;
                r_rd_idx     <= '0;
            end else if (issue) begin
                if (last_idx) begin
                    r_rd_idx     <= '0;
                    r_ticks_left <= r_ticks_left - 2'd1;
                    r_time       <= r_time + 1'b1;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end

            if (!stall) begin
                r_chk_valid <= issue;
            end

            // held expiry goes out with last set once the scan is over
            if (hit && !stall) begin
                r_pend_valid <= 1'b1;
            end else if (flush_push) begin
                r_pend_valid <= 1'b0;
            end

            if ((hit && !stall && r_pend_valid) || flush_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_chk_idx  <= r_rd_idx;
            r_chk_time <= r_time;
        end
        if (hit && !stall) begin
            r_pend <= hit_item;
            if (r_pend_valid) begin
                r_out <= pend_out;
            end
        end else if (flush_push) begin
            r_out <= pend_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid && !r_chk_valid && (r_ticks_left == '0))
        else $error("idle with scan work outstanding");

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> (r_state == ST_SCAN))
        else $error("check stage busy outside scan");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> r_chk_valid && $stable(r_chk_idx) && $stable(r_rd_idx))
        else $error("scan moved on during a stall");

    a_tick_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && last_idx) |=> (r_time == $past(r_time) + 1'b1) && (r_rd_idx == '0))
        else $error("tick did not advance at end of table pass");

endmodule
